// ===== rtl/core/keuf_pkg.sv =====
// Shared constants, item codes and controller/datapath interface types.
package keuf_pkg;

   localparam int NODE_W        = 7;
   localparam int WEIGHT_W      = 32;
   localparam int COST_W        = 40;
   localparam int RANK_W        = 3;
   localparam int MAX_NODES_DEF = 128;

   localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

   localparam logic ACTION_CLEAR = 1'b0;
   localparam logic ACTION_EDGE  = 1'b1;

   typedef struct packed {
      logic load_req;
      logic side_to_b;
      logic sweep_wr;
      logic walk_start;
      logic walk_step;
      logic root_capture;
      logic comp_wr;
      logic link_wr;
      logic bump_wr;
      logic cost_clear;
      logic cost_add;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_root;
      logic at_root;
      logic next_is_root;
      logic roots_differ;
      logic rank_tie;
      logic sweep_last;
      logic side_b;
   } dp_sts_type;

endpackage

// ===== rtl/core/keuf_datapath.sv =====
// Datapath: node memory, walk registers, running total and result register.
module keuf_datapath #(
   parameter int MAX_NODES = keuf_pkg::MAX_NODES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [keuf_pkg::NODE_W-1:0]      req_node_a,
   input  logic [keuf_pkg::NODE_W-1:0]      req_node_b,
   input  logic [keuf_pkg::WEIGHT_W-1:0]    req_weight,
   input  keuf_pkg::dp_cmd_type             cmd,
   output keuf_pkg::dp_sts_type             sts,
   output logic                             rsp_accepted,
   output logic [keuf_pkg::COST_W-1:0]      rsp_total_cost
);
   import keuf_pkg::*;

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int ENT_W = RANK_W + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

   // Each entry holds {rank, parent}.
   logic [ENT_W-1:0] node_mem [MAX_NODES];

   logic [NODE_W-1:0]   node_a_ff, node_b_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                side_b_ff, side_b_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    root_a_ff, root_b_ff;
   logic [RANK_W-1:0]   rank_a_ff, rank_b_ff;
   logic [ENT_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]    sweep_ff, sweep_in;
   logic [COST_W-1:0]   cost_ff, cost_in;
   logic                acc_ff, acc_in;
   logic                rsp_accepted_ff;
   logic [COST_W-1:0]   rsp_total_ff;

   logic [NODE_W-1:0]   side_node;
   logic [IDX_W-1:0]    side_idx;
   logic [IDX_W-1:0]    rd_parent;
   logic [RANK_W-1:0]   rd_rank;
   logic [IDX_W-1:0]    root_side;
   logic [RANK_W-1:0]   rank_bump;
   logic [COST_W:0]     cost_sum;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENT_W-1:0]    wr_data;

   assign side_node = side_b_ff ? node_b_ff : node_a_ff;
   assign side_idx  = IDX_W'(side_node);
   assign rd_parent = rd_data_ff[IDX_W-1:0];
   assign rd_rank   = rd_data_ff[ENT_W-1:IDX_W];
   assign root_side = side_b_ff ? root_b_ff : root_a_ff;
   assign rank_bump = (rank_b_ff == RANK_MAX) ? RANK_MAX : rank_b_ff + RANK_W'(1);
   assign cost_sum  = {1'b0, cost_ff} + (COST_W + 1)'(weight_ff);

   always_comb begin
      rd_en   = cmd.walk_start | cmd.walk_step;
      rd_addr = cmd.walk_start ? side_idx : rd_parent;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = {rd_rank, root_side};
      if (cmd.sweep_wr) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = {RANK_W'(0), sweep_ff};
      end else if (cmd.comp_wr) begin
         wr_en   = 1'b1;
      end else if (cmd.link_wr) begin
         wr_en = 1'b1;
         // The root of lower rank goes under the other; on a tie a goes under b.
         if (rank_a_ff > rank_b_ff) begin
            wr_addr = root_b_ff;
            wr_data = {rank_b_ff, root_a_ff};
         end else begin
            wr_addr = root_a_ff;
            wr_data = {rank_a_ff, root_b_ff};
         end
      end else if (cmd.bump_wr) begin
         wr_en   = 1'b1;
         wr_addr = root_b_ff;
         wr_data = {rank_bump, root_b_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_addr];
      end
   end

   always_comb begin
      side_b_in = side_b_ff;
      if (cmd.load_req) begin
         side_b_in = 1'b0;
      end else if (cmd.side_to_b) begin
         side_b_in = 1'b1;
      end
      cur_in = cur_ff;
      if (cmd.walk_start) begin
         cur_in = side_idx;
      end else if (cmd.walk_step) begin
         cur_in = rd_parent;
      end
      sweep_in = sweep_ff;
      if (cmd.sweep_wr) begin
         sweep_in = (sweep_ff == LAST_IDX) ? '0 : sweep_ff + IDX_W'(1);
      end
      cost_in = cost_ff;
      if (cmd.cost_clear) begin
         cost_in = '0;
      end else if (cmd.cost_add) begin
         cost_in = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
      end
      acc_in = acc_ff;
      if (cmd.load_req) begin
         acc_in = 1'b0;
      end else if (cmd.cost_add) begin
         acc_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_b_ff <= 1'b0;
         cur_ff    <= '0;
         sweep_ff  <= '0;
         acc_ff    <= 1'b0;
      end else begin
         side_b_ff <= side_b_in;
         cur_ff    <= cur_in;
         sweep_ff  <= sweep_in;
         acc_ff    <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      cost_ff <= cost_in;
      if (cmd.load_req) begin
         node_a_ff <= req_node_a;
         node_b_ff <= req_node_b;
         weight_ff <= req_weight;
      end
      if (cmd.root_capture) begin
         if (side_b_ff) begin
            root_b_ff <= cur_ff;
            rank_b_ff <= rd_rank;
         end else begin
            root_a_ff <= cur_ff;
            rank_a_ff <= rd_rank;
         end
      end
      if (cmd.rsp_load) begin
         rsp_accepted_ff <= acc_ff;
         rsp_total_ff    <= cost_ff;
      end
   end

   always_comb begin
      sts.in_range     = (int'(node_a_ff) < MAX_NODES) && (int'(node_b_ff) < MAX_NODES);
      sts.is_root      = (rd_parent == cur_ff);
      sts.at_root      = (cur_ff == root_side);
      sts.next_is_root = (rd_parent == root_side);
      sts.roots_differ = (root_a_ff != root_b_ff);
      sts.rank_tie     = (rank_a_ff == rank_b_ff);
      sts.sweep_last   = (sweep_ff == LAST_IDX);
      sts.side_b       = side_b_ff;
   end

   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_total_cost = rsp_total_ff;

endmodule

// ===== rtl/core/keuf_ctrl.sv =====
// Controller: sequences table clears, root walks, path compression and linking.
module keuf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  keuf_pkg::dp_sts_type sts,
   output keuf_pkg::dp_cmd_type cmd
);
   import keuf_pkg::*;

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_CLEAR  = 4'd2;
   localparam logic [3:0] ST_START  = 4'd3;
   localparam logic [3:0] ST_FIND   = 4'd4;
   localparam logic [3:0] ST_COMP   = 4'd5;
   localparam logic [3:0] ST_LINK   = 4'd6;
   localparam logic [3:0] ST_BUMP   = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_wr   = 1'b1;
            cmd.cost_clear = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = (req_action == ACTION_CLEAR) ? ST_CLEAR : ST_START;
            end
         end
         ST_CLEAR: begin
            cmd.sweep_wr   = 1'b1;
            cmd.cost_clear = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_START: begin
            if (!sts.in_range) begin
               state_in = ST_FINISH;
            end else begin
               cmd.walk_start = 1'b1;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (sts.is_root) begin
               // Root known: restart from the endpoint to compress its path.
               cmd.root_capture = 1'b1;
               cmd.walk_start   = 1'b1;
               state_in = ST_COMP;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_COMP: begin
            if (sts.at_root || sts.next_is_root) begin
               cmd.comp_wr = !sts.at_root;
               if (sts.side_b) begin
                  state_in = ST_LINK;
               end else begin
                  cmd.side_to_b = 1'b1;
                  state_in = ST_START;
               end
            end else begin
               cmd.comp_wr   = 1'b1;
               cmd.walk_step = 1'b1;
            end
         end
         ST_LINK: begin
            if (sts.roots_differ) begin
               cmd.link_wr  = 1'b1;
               cmd.cost_add = 1'b1;
               state_in = sts.rank_tie ? ST_BUMP : ST_FINISH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_BUMP: begin
            cmd.bump_wr = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/kruskal_edge_union_find.sv =====
// Top level of the Kruskal edge acceptance stage over a union-find forest.
// Items enter on the req_ channel: req_action clears all sets and the total,
// or offers the edge req_node_a to req_node_b with length req_weight (Q16.16).
// Edges are expected in ascending weight order. Each item gives one result on
// the rsp_ channel: rsp_accepted and the saturating running total (Q24.16).
// One item is worked on at a time; req_stall is low only while idle.
// For an edge, each endpoint is walked up to the root of its tree and its path
// then compressed; each step of a root walk or compression pass is one read of
// the node memory. A tie in rank adds the rank update. An endpoint at or beyond
// MAX_NODES gives a result without a walk.
// A clear rewrites the node memory one entry a cycle.
// After reset the same pass runs with req_stall high.
// The result sits in an output register; while rsp_stall is high it holds,
// and the next item may still be accepted and worked on meanwhile.
module kruskal_edge_union_find #(
   parameter int MAX_NODES = keuf_pkg::MAX_NODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [keuf_pkg::NODE_W-1:0]   req_node_a,
   input  logic [keuf_pkg::NODE_W-1:0]   req_node_b,
   input  logic [keuf_pkg::WEIGHT_W-1:0] req_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic [keuf_pkg::COST_W-1:0]   rsp_total_cost
);
   import keuf_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   keuf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   keuf_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .req_weight     (req_weight),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_accepted   (rsp_accepted),
      .rsp_total_cost (rsp_total_cost)
   );

endmodule

// ===== rtl/core/keuf_checker.sv =====
// Port-level checks for the Kruskal edge stage, bound to the top level.
module keuf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_accepted,
   input logic [keuf_pkg::COST_W-1:0] rsp_total_cost
);
   import keuf_pkg::*;

   logic              req_take;
   logic              rsp_take;
   logic [1:0]        pending_ff, pending_in;
   logic [COST_W-1:0] last_total_ff;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         last_total_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_take) begin
            last_total_ff <= rsp_total_cost;
         end
      end
   end

   // The node memory is rewritten after reset, so no item is taken at once.
   a_stall_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("item taken right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accepted)
                                 && $stable(rsp_total_cost))
      else $error("stalled result changed");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an item");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_take |-> pending_ff != 2'd2)
      else $error("item taken while another waits behind a held result");

   // Between clears the total never falls; a clear reports zero.
   a_total_rises: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp_total_cost >= last_total_ff) || (rsp_total_cost == '0))
      else $error("running total decreased");

endmodule

bind kruskal_edge_union_find keuf_checker u_keuf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_accepted   (rsp_accepted),
   .rsp_total_cost (rsp_total_cost)
);
